>>> design/qtrc_pkg.sv
package qtrc_pkg;

	localparam int TABLE_LEN     = 24;
	localparam int CORDIC_DEF    = 16;
	localparam int ACC_W         = 34;   // CORDIC vector width
	localparam int ANG_W         = 28;   // Q.24 angle accumulator
	localparam int SQ_W          = 58;   // square-root radicand width
	localparam int RT_W          = 29;   // square-root result width
	localparam int DIV_W         = 15;   // limit width
	localparam int RATIO_W       = 31;   // |angle| << 16
	localparam logic signed [ANG_W-1:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [15:0]      ANGLE_MAX = 16'sd25736;
	localparam logic [14:0] PITCH_RST = 15'd5734;
	localparam logic [14:0] ROLL_RST  = 15'd7373;
	localparam logic [16:0] RISK_ONE  = 17'd65536;

	localparam logic CFG_PITCH = 1'b0;
	localparam logic CFG_ROLL  = 1'b1;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic [7:0]         red_level;
		logic [7:0]         green_level;
	} out_word_t;

	// vector passed along the CORDIC chain
	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ANG_W-1:0] acc;
		logic                    fixed;  // result settled by a zero numerator
	} cvec_t;

	// payload of one pipeline slot besides the CORDIC vectors
	typedef struct packed {
		logic               valid;
	} slot_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		logic signed [ANG_W-1:0] t [TABLE_LEN];
		t = '{28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
		      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
		      28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
		      28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2};
		return (i < TABLE_LEN) ? t[i] : '0;
	endfunction

	// Q.24 angle to Q2.13 with rounding and clamp
	function automatic logic signed [15:0] to_q13(input logic signed [ANG_W:0] a);
		logic signed [ANG_W:0] r;
		r = (a + (ANG_W+1)'(1024)) >>> 11;
		if (r > (ANG_W+1)'(ANGLE_MAX))       return ANGLE_MAX;
		else if (r < -(ANG_W+1)'(ANGLE_MAX)) return -ANGLE_MAX;
		else                                 return r[15:0];
	endfunction

	// red/green level from Q.16 value
	function automatic logic [7:0] level8(input logic [16:0] v);
		logic [26:0] p;
		p = 27'(v) * 27'd765 + 27'd131072;
		return p[25:18];
	endfunction

endpackage

>>> design/qtrc_sqrt_cell.sv
// one digit of a restoring square root, two radicand bits per cell
module qtrc_sqrt_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qtrc_pkg::SQ_W-1:0]  rem_in,
	input  logic [qtrc_pkg::RT_W-1:0]  root_in,
	input  logic [qtrc_pkg::SQ_W-1:0]  rad_in,
	output logic [qtrc_pkg::SQ_W-1:0]  rem_out,
	output logic [qtrc_pkg::RT_W-1:0]  root_out,
	output logic [qtrc_pkg::SQ_W-1:0]  rad_out
);
	import qtrc_pkg::*;

	logic [SQ_W-1:0] rem_w, trial;
	logic            take;

	always_comb begin
		rem_w = {rem_in[SQ_W-3:0], rad_in[SQ_W-1 -: 2]};
		trial = SQ_W'({root_in[RT_W-2:0], 2'b01});
		take  = rem_w >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? rem_w - trial : rem_w;
			root_out <= {root_in[RT_W-2:0], take};
			rad_out  <= {rad_in[SQ_W-3:0], 2'b00};
		end
	end
endmodule

>>> design/qtrc_cordic_cell.sv
// one vectoring CORDIC micro-rotation
module qtrc_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            en,
	input  qtrc_pkg::cvec_t vin,
	output qtrc_pkg::cvec_t vout
);
	import qtrc_pkg::*;

	logic signed [ACC_W-1:0] xs, ys;
	cvec_t nxt;

	always_comb begin
		xs  = vin.x >>> IDX;
		ys  = vin.y >>> IDX;
		nxt = vin;
		if (!vin.fixed) begin
			if (vin.y >= 0) begin
				nxt.x   = vin.x + ys;
				nxt.y   = vin.y - xs;
				nxt.acc = vin.acc + atan_entry(IDX);
			end else begin
				nxt.x   = vin.x - ys;
				nxt.y   = vin.y + xs;
				nxt.acc = vin.acc - atan_entry(IDX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) vout <= nxt;
	end
endmodule

>>> design/qtrc_div_cell.sv
// one quotient bit of a restoring division by a limit
module qtrc_div_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qtrc_pkg::RATIO_W-1:0] num_in,
	input  logic [qtrc_pkg::DIV_W:0]     rem_in,
	input  logic [qtrc_pkg::DIV_W-1:0]   den_in,
	output logic [qtrc_pkg::RATIO_W-1:0] num_out,
	output logic [qtrc_pkg::DIV_W:0]     rem_out,
	output logic [qtrc_pkg::DIV_W-1:0]   den_out
);
	import qtrc_pkg::*;

	logic [DIV_W+1:0] r2;
	logic             take;

	always_comb begin
		r2   = {rem_in, num_in[RATIO_W-1]};
		take = r2 >= (DIV_W+2)'(den_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? (DIV_W+1)'(r2 - (DIV_W+2)'(den_in)) : r2[DIV_W:0];
			num_out <= {num_in[RATIO_W-2:0], take};
			den_out <= den_in;
		end
	end
endmodule

>>> design/quaternion_tilt_risk_color_top.sv
// Quaternion tilt-risk colour.
// Input channel in_valid/in_stall/in_word carries one Q1.14 quaternion word.
// Output channel out_valid/out_stall/out_word carries pitch and roll (Q2.13 rad)
// and the red and green levels of the green-yellow-red risk colour.
// cfg_we/cfg_index/cfg_data write pitch_limit (0) and roll_limit (1). Write only
// while the block is idle.
// Throughput: one word per cycle while the skid register is empty. Words pass
// through the chain of cells in order: products and sine clamp (2), square-root
// cells (29), the pitch and roll CORDIC rows side by side (CORDIC_STAGES cells,
// at most 24), one divider cell per quotient bit (31), the colour stage and the
// output register.
// The whole chain advances as one. When the receiver stalls, the next word out of
// the chain drops into a one-word skid register; while that register is full
// every cell holds and in_stall is high, so in_stall comes from a register and
// never follows out_stall in the same cycle.
// Reset clears the valid bits and restores both limits to their defaults.
module quaternion_tilt_risk_color_top #(
	parameter int CORDIC_STAGES = qtrc_pkg::CORDIC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qtrc_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output qtrc_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [14:0]         cfg_data
);
	import qtrc_pkg::*;

	localparam int NST  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int NSQ  = RT_W;
	localparam int NDV  = RATIO_W;
	localparam int LAT  = 2 + NSQ + NST + NDV + 1;

	logic [14:0] pitch_lim_q, roll_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_lim_q <= PITCH_RST;
			roll_lim_q  <= ROLL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PITCH: pitch_lim_q <= cfg_data;
				CFG_ROLL:  roll_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// the chain advances while the skid register is empty; a full skid holds
	// every cell and the input
	logic [LAT-1:0]  vld_q;
	logic            adv;
	logic            acc_in, acc_out;
	logic            chain_out_v;
	out_word_t       chain_out;
	logic            out_v_q, skid_v_q;
	out_word_t       out_q, skid_q;

	assign adv         = !skid_v_q;
	assign in_stall    = skid_v_q;
	assign acc_in      = in_valid && !in_stall;
	assign out_valid   = out_v_q;
	assign out_word    = out_q;
	assign acc_out     = out_v_q && !out_stall;
	assign chain_out_v = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0; out_v_q <= 1'b0; skid_v_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], acc_in};
			// take the chain word into the output, or park it in the skid
			if (!out_v_q || acc_out) out_v_q <= chain_out_v;
			else if (chain_out_v)    skid_v_q <= 1'b1;
		end else if (acc_out) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!out_v_q || acc_out) out_q  <= chain_out;
			else if (chain_out_v)    skid_q <= chain_out;
		end else if (acc_out) begin
			out_q <= skid_q;
		end
	end

	// stage 1: products
	logic signed [33:0] num_s1, den_s1, s_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= 34'(2 * (34'(in_word.quat_y) * in_word.quat_z + 34'(in_word.quat_w) * in_word.quat_x));
			den_s1 <= 34'(in_word.quat_z) * in_word.quat_z - 34'(in_word.quat_y) * in_word.quat_y
				- 34'(in_word.quat_x) * in_word.quat_x + 34'(in_word.quat_w) * in_word.quat_w;
			s_s1 <= 34'(2 * (34'(in_word.quat_x) * in_word.quat_z - 34'(in_word.quat_w) * in_word.quat_y));
		end
	end

	// stage 2: saturate sine, form radicand
	logic signed [33:0] s_s2, num_s2, den_s2;
	logic [SQ_W-1:0]    rad_s2;
	logic signed [33:0] s_sat;
	logic [28:0]        mag;
	always_comb begin
		s_sat = s_s1;
		if (s_s1 > 34'sd268435456)  s_sat = 34'sd268435456;
		if (s_s1 < -34'sd268435456) s_sat = -34'sd268435456;
		mag = s_sat < 0 ? 29'(-s_sat) : 29'(s_sat);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2   <= s_sat;
			num_s2 <= num_s1;
			den_s2 <= den_s1;
			rad_s2 <= (SQ_W'(1) << 56) - SQ_W'(58'(mag) * 58'(mag));
		end
	end

	// square-root chain, sine and roll vector ride alongside
	logic [SQ_W-1:0]    sq_rem [NSQ+1];
	logic [RT_W-1:0]    sq_rt  [NSQ+1];
	logic [SQ_W-1:0]    sq_rad [NSQ+1];
	logic signed [33:0] sq_s [NSQ+1], sq_n [NSQ+1], sq_d [NSQ+1];
	assign sq_rem[0] = '0;
	assign sq_rt[0]  = '0;
	assign sq_rad[0] = rad_s2;
	assign sq_s[0] = s_s2; assign sq_n[0] = num_s2; assign sq_d[0] = den_s2;
	for (genvar g = 0; g < NSQ; g++) begin : g_sq
		qtrc_sqrt_cell u_cell (
			.clk, .en(adv), .rem_in(sq_rem[g]), .root_in(sq_rt[g]), .rad_in(sq_rad[g]),
			.rem_out(sq_rem[g+1]), .root_out(sq_rt[g+1]), .rad_out(sq_rad[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[g+1] <= sq_s[g]; sq_n[g+1] <= sq_n[g]; sq_d[g+1] <= sq_d[g];
			end
		end
	end

	// CORDIC chains: pitch and roll in parallel rows
	function automatic cvec_t pre(input logic signed [33:0] y, input logic signed [33:0] x);
		cvec_t v;
		v.x = x; v.y = y; v.acc = '0; v.fixed = 1'b0;
		if (y == 0) begin
			v.fixed = 1'b1;
			v.acc   = (x >= 0) ? '0 : PI_Q24;
		end else if (x < 0) begin
			v.acc = (y > 0) ? PI_Q24 : -PI_Q24;
			v.x = -x; v.y = -y;
		end
		return v;
	endfunction

	cvec_t pv [NST+1], rv [NST+1];
	assign pv[0] = pre(sq_s[NSQ], 34'(sq_rt[NSQ]));
	assign rv[0] = pre(sq_n[NSQ], sq_d[NSQ]);
	for (genvar g = 0; g < NST; g++) begin : g_cor
		qtrc_cordic_cell #(.IDX(g)) u_p (.clk, .en(adv), .vin(pv[g]), .vout(pv[g+1]));
		qtrc_cordic_cell #(.IDX(g)) u_r (.clk, .en(adv), .vin(rv[g]), .vout(rv[g+1]));
	end

	logic signed [15:0] pitch_c, roll_c;
	assign pitch_c = to_q13(-(ANG_W+1)'(pv[NST].acc));
	assign roll_c  = to_q13((ANG_W+1)'(rv[NST].acc));

	// divider chains
	logic [RATIO_W-1:0] pn [NDV+1], rn [NDV+1];
	logic [DIV_W:0]     pr [NDV+1], rr [NDV+1];
	logic [DIV_W-1:0]   pd [NDV+1], rd [NDV+1];
	logic signed [15:0] pa [NDV+1], ra [NDV+1];
	assign pn[0] = RATIO_W'(pitch_c < 0 ? -pitch_c : pitch_c) << 16;
	assign rn[0] = RATIO_W'(roll_c < 0 ? -roll_c : roll_c) << 16;
	assign pr[0] = '0; assign rr[0] = '0;
	assign pd[0] = pitch_lim_q == '0 ? DIV_W'(1) : pitch_lim_q;
	assign rd[0] = roll_lim_q  == '0 ? DIV_W'(1) : roll_lim_q;
	assign pa[0] = pitch_c; assign ra[0] = roll_c;
	for (genvar g = 0; g < NDV; g++) begin : g_div
		qtrc_div_cell u_p (.clk, .en(adv), .num_in(pn[g]), .rem_in(pr[g]), .den_in(pd[g]),
			.num_out(pn[g+1]), .rem_out(pr[g+1]), .den_out(pd[g+1]));
		qtrc_div_cell u_r (.clk, .en(adv), .num_in(rn[g]), .rem_in(rr[g]), .den_in(rd[g]),
			.num_out(rn[g+1]), .rem_out(rr[g+1]), .den_out(rd[g+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				pa[g+1] <= pa[g]; ra[g+1] <= ra[g];
			end
		end
	end

	// colour stage
	logic [RATIO_W:0] rsum;
	logic [16:0]      risk, red, green;
	always_comb begin
		rsum  = (RATIO_W+1)'(pn[NDV]) + (RATIO_W+1)'(rn[NDV]);
		risk  = rsum > (RATIO_W+1)'(RISK_ONE) ? RISK_ONE : rsum[16:0];
		red   = risk >= 17'd32768 ? RISK_ONE : 17'(risk << 1);
		green = risk <= 17'd32768 ? RISK_ONE : 17'((RISK_ONE - risk) << 1);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			chain_out.pitch_angle <= pa[NDV];
			chain_out.roll_angle  <= ra[NDV];
			chain_out.red_level   <= level8(red);
			chain_out.green_level <= level8(green);
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid word without output word");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");
	a_red_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.red_level <= 8'd191 && out_word.green_level <= 8'd191)
		else $error("level out of range");
`endif
endmodule
